@@ design/cau_pkg.sv @@
// Shared constants and pipeline types for the complex arithmetic unit.
`timescale 1ns / 1ps

package cau_pkg;

  localparam int FRAC_BITS = 8;
  localparam int OPND_W    = 16;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int DEN_W     = PROD_W;
  localparam int MAG_W     = PROD_W + FRAC_BITS;
  localparam int QB        = OPND_W + 1;
  localparam int PRE_W     = PROD_W + 2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QB-1:0]    lo;
    logic [QB-1:0]    q;
    logic             ovf;
    logic             neg;
  } lane_t;

  typedef struct packed {
    logic                    valid;
    logic [1:0]              op;
    logic                    dz;
    logic [DEN_W-1:0]        den;
    logic signed [PRE_W-1:0] pre_re;
    logic signed [PRE_W-1:0] pre_im;
    lane_t                   ln_re;
    lane_t                   ln_im;
  } beat_t;

endpackage

@@ design/cau_cell.sv @@
// One divider cell: resolves one quotient bit per lane and hands the beat on.
`timescale 1ns / 1ps

module cau_cell import cau_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  beat_t d_in,
  output beat_t d_out
);

  beat_t beat_r, beat_nxt;

  function automatic lane_t step(input lane_t l, input logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    logic           ge;
    lane_t          r;
    t    = {l.rem, l.lo[QB-1]};
    diff = t - {1'b0, den};
    ge   = (t >= {1'b0, den});
    r     = l;
    r.rem = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
    r.lo  = {l.lo[QB-2:0], 1'b0};
    r.q   = {l.q[QB-2:0], ge};
    return r;
  endfunction

  always_comb begin
    beat_nxt       = d_in;
    beat_nxt.ln_re = step(d_in.ln_re, d_in.den);
    beat_nxt.ln_im = step(d_in.ln_im, d_in.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  assign d_out = beat_r;

endmodule

@@ design/cau_front.sv @@
// Operand products, sums and divider setup ahead of the cell chain.
`timescale 1ns / 1ps

module cau_front import cau_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_fire,
  input  logic [1:0]               op,
  input  logic signed [OPND_W-1:0] ar,
  input  logic signed [OPND_W-1:0] ai,
  input  logic signed [OPND_W-1:0] br,
  input  logic signed [OPND_W-1:0] bi,
  output beat_t                    d_out
);

  logic                     v1_r;
  logic [1:0]               op1_r;
  logic signed [PRE_W-1:0]  add_re_r, add_im_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic [PROD_W-1:0]        p_bb_r, p_cc_r;
  beat_t                    beat_r, beat_nxt;

  always_ff @(posedge clk) begin
    op1_r    <= op;
    add_re_r <= (op == OP_SUB) ? PRE_W'(ar) - PRE_W'(br) : PRE_W'(ar) + PRE_W'(br);
    add_im_r <= (op == OP_SUB) ? PRE_W'(ai) - PRE_W'(bi) : PRE_W'(ai) + PRE_W'(bi);
    p_rr_r   <= ar * br;
    p_ii_r   <= ai * bi;
    p_ri_r   <= ar * bi;
    p_ir_r   <= ai * br;
    p_bb_r   <= PROD_W'(br * br);
    p_cc_r   <= PROD_W'(bi * bi);
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
    end
  end

  function automatic lane_t setup(input logic signed [PROD_W:0] num,
                                  input logic [DEN_W-1:0] den);
    logic [PROD_W:0]  a;
    logic [MAG_W-1:0] mag;
    lane_t            l;
    a     = num[PROD_W] ? -num : num;
    mag   = {a[PROD_W-1:0], {FRAC_BITS{1'b0}}};
    l.neg = num[PROD_W];
    l.ovf = ({{(DEN_W+QB-MAG_W){1'b0}}, mag} >= {den, {QB{1'b0}}});
    l.rem = DEN_W'(mag >> QB);
    l.lo  = mag[QB-1:0];
    l.q   = '0;
    return l;
  endfunction

  always_comb begin
    logic signed [PROD_W:0] mre, mim, nre, nim;
    mre = PROD_W'(0) + (PROD_W+1)'(p_rr_r) - (PROD_W+1)'(p_ii_r);
    mim = (PROD_W+1)'(p_ri_r) + (PROD_W+1)'(p_ir_r);
    nre = (PROD_W+1)'(p_rr_r) + (PROD_W+1)'(p_ii_r);
    nim = (PROD_W+1)'(p_ir_r) - (PROD_W+1)'(p_ri_r);
    beat_nxt.valid = v1_r;
    beat_nxt.op    = op1_r;
    beat_nxt.den   = p_bb_r + p_cc_r;
    beat_nxt.dz    = (beat_nxt.den == '0);
    if (op1_r == OP_MUL) begin
      beat_nxt.pre_re = PRE_W'(mre >>> FRAC_BITS);
      beat_nxt.pre_im = PRE_W'(mim >>> FRAC_BITS);
    end else begin
      beat_nxt.pre_re = add_re_r;
      beat_nxt.pre_im = add_im_r;
    end
    beat_nxt.ln_re = setup(nre, beat_nxt.den);
    beat_nxt.ln_im = setup(nim, beat_nxt.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  assign d_out = beat_r;

endmodule

@@ design/complex_arithmetic_unit.sv @@
// Top level of the complex arithmetic unit: front end, divider cell chain, clamp.
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------------
//  input    | start, busy      | in_opcode, in_a_real/imag, in_b_real/imag
//  result   | out_valid strobe | out_result_real/imag, out_saturated,
//           |                  | out_divide_by_zero
//
// One beat is accepted every cycle; busy is always low.
// Every beat, whatever its opcode, runs from start through the front-end registers,
// the 17-cell quotient chain and the output register to its out_valid strobe.
// Synchronous reset clears the front-end valid and beat registers and the cell chain and drops out_valid.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module complex_arithmetic_unit import cau_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_opcode,
  input  logic signed [OPND_W-1:0] in_a_real,
  input  logic signed [OPND_W-1:0] in_a_imag,
  input  logic signed [OPND_W-1:0] in_b_real,
  input  logic signed [OPND_W-1:0] in_b_imag,
  output logic                     out_valid,
  output logic signed [OPND_W-1:0] out_result_real,
  output logic signed [OPND_W-1:0] out_result_imag,
  output logic                     out_saturated,
  output logic                     out_divide_by_zero
);

  localparam logic signed [PRE_W:0] MAX_V = (PRE_W+1)'((1 << (OPND_W-1)) - 1);
  localparam logic signed [PRE_W:0] MIN_V = -(PRE_W+1)'(1 << (OPND_W-1));

  beat_t chain [QB+1];

  logic                     vld_r;
  logic signed [OPND_W-1:0] re_r, im_r;
  logic                     sat_r, dz_r;
  logic signed [OPND_W-1:0] re_nxt, im_nxt;
  logic                     sat_nxt, dz_nxt;

  assign busy = 1'b0;

  cau_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(start && !busy),
    .op     (in_opcode),
    .ar     (in_a_real),
    .ai     (in_a_imag),
    .br     (in_b_real),
    .bi     (in_b_imag),
    .d_out  (chain[0])
  );

  for (genvar g = 0; g < QB; g++) begin : g_cell
    cau_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .d_in (chain[g]),
      .d_out(chain[g+1])
    );
  end

  function automatic logic signed [PRE_W:0] lane_val(input lane_t l);
    logic signed [PRE_W:0] q;
    q = (PRE_W+1)'(l.q);
    if (l.ovf) begin
      return l.neg ? MIN_V - 1 : MAX_V + 1;
    end
    return l.neg ? -q : q;
  endfunction

  function automatic logic signed [OPND_W-1:0] clamp(input logic signed [PRE_W:0] v,
                                                     output logic s);
    s = 1'b0;
    if (v > MAX_V) begin
      s = 1'b1;
      return OPND_W'(MAX_V);
    end
    if (v < MIN_V) begin
      s = 1'b1;
      return OPND_W'(MIN_V);
    end
    return OPND_W'(v);
  endfunction

  always_comb begin
    beat_t                 b;
    logic signed [PRE_W:0] vre, vim;
    logic                  sre, sim;
    b = chain[QB];
    if (b.op == OP_DIV) begin
      vre = lane_val(b.ln_re);
      vim = lane_val(b.ln_im);
    end else begin
      vre = (PRE_W+1)'(b.pre_re);
      vim = (PRE_W+1)'(b.pre_im);
    end
    re_nxt  = clamp(vre, sre);
    im_nxt  = clamp(vim, sim);
    sat_nxt = sre | sim;
    dz_nxt  = 1'b0;
    if (b.op == OP_DIV && b.dz) begin
      re_nxt  = '0;
      im_nxt  = '0;
      sat_nxt = 1'b0;
      dz_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    re_r  <= re_nxt;
    im_r  <= im_nxt;
    sat_r <= sat_nxt;
    dz_r  <= dz_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= chain[QB].valid;
    end
  end

  assign out_valid          = vld_r;
  assign out_result_real    = re_r;
  assign out_result_imag    = im_r;
  assign out_saturated      = sat_r;
  assign out_divide_by_zero = dz_r;

endmodule

@@ design/cau_checker.sv @@
// Port-level checks for the complex arithmetic unit, bound to the top level.
`timescale 1ns / 1ps

module cau_checker import cau_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic [1:0]               in_opcode,
  input logic                     out_valid,
  input logic signed [OPND_W-1:0] out_result_real,
  input logic signed [OPND_W-1:0] out_result_imag,
  input logic                     out_saturated,
  input logic                     out_divide_by_zero
);

  localparam int LAT = QB + 3;

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after fixed latency");

  a_dz_op: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode != OP_DIV) |-> ##LAT !out_divide_by_zero)
    else $error("divide-by-zero flag on non-divide beat");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |->
      (out_result_real == '0 && out_result_imag == '0 && !out_saturated))
    else $error("divide-by-zero result not cleared");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
